>>> hdl/dtas_pkg.sv
// shared types, constants and the month length function for the date-time shifter
// no dependencies
`default_nettype none

package dtas_pkg;

    // widths of the internal arithmetic
    localparam int OFF_W  = 33;  // biased seconds offset, always non-negative
    localparam int QD_W   = 16;  // biased day quotient
    localparam int DAYC_W = 18;  // signed day count during the month walk
    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int IDX_W  = 1;
    localparam int YQ_W   = 6;   // year / 400

    // time constants
    localparam logic [OFF_W-1:0] SECS_DAY  = 33'd86400;
    localparam logic [OFF_W-1:0] SECS_HOUR = 33'd3600;
    localparam logic [OFF_W-1:0] SECS_MIN  = 33'd60;

    // offset bias keeps the dividend positive: off + DAY_BIAS days
    // (day is added unshifted, so one day less is folded in here)
    localparam logic [DAYC_W-1:0] DAY_BIAS = 18'd24900;
    localparam logic [OFF_W-1:0]  OFF_BIAS = 33'd2151273600;

    // calendar constants
    localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd16383;
    localparam logic [YEAR_W-1:0] YEAR_MIN   = 14'd0;
    localparam logic [YEAR_W-1:0] YEAR_CYCLE = 14'd400;
    localparam logic [YEAR_W-1:0] YMOD_LAST  = 14'd399;
    localparam logic [YEAR_W-1:0] CENTURY    = 14'd100;
    localparam logic [MON_W-1:0]  MON_JAN    = 4'd1;
    localparam logic [MON_W-1:0]  MON_FEB    = 4'd2;
    localparam logic [MON_W-1:0]  MON_APR    = 4'd4;
    localparam logic [MON_W-1:0]  MON_JUN    = 4'd6;
    localparam logic [MON_W-1:0]  MON_SEP    = 4'd9;
    localparam logic [MON_W-1:0]  MON_NOV    = 4'd11;
    localparam logic [MON_W-1:0]  MON_DEC    = 4'd12;
    localparam logic [4:0]        DAYS_LONG  = 5'd31;

    // reciprocal dividers: x / (k << p) = ((x >> p) * m) >> s, exact over each operand range
    localparam int          DAY_PRE   = 7;   // 86400 = 675 << 7
    localparam int          DAY_SH    = 36;
    localparam logic [26:0] DAY_RECIP = 27'd101806633;
    localparam int          HR_PRE    = 4;   // 3600 = 225 << 4
    localparam int          HR_SH     = 21;
    localparam logic [13:0] HR_RECIP  = 14'd9321;
    localparam int          MIN_PRE   = 2;   // 60 = 15 << 2
    localparam int          MIN_SH    = 14;
    localparam logic [10:0] MIN_RECIP = 11'd1093;
    localparam int          YR_PRE    = 4;   // 400 = 25 << 4
    localparam int          YR_SH     = 15;
    localparam logic [10:0] YR_RECIP  = 11'd1311;

    // two steps per division: quotient, then remainder
    localparam logic [IDX_W-1:0] STEP_QUO = 1'b1;
    localparam logic [IDX_W-1:0] STEP_REM = 1'b0;

    // opcode
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic             load;
        logic             offs;
        logic             div_step;
        logic             ymod_step;
        logic             hrs_step;
        logic             min_step;
        logic             walk;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } dtas_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic walk_done;
    } dtas_status_t;

    // days in a month given the leap flag of its year
    function automatic logic [4:0] month_len(input logic [MON_W-1:0] m, input logic leap);
        logic [4:0] len;
        len = DAYS_LONG;
        if (m == MON_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
            len = 5'd30;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

>>> hdl/dtas_datapath.sv
// datapath: input capture, offset sum, reciprocal-multiply dividers,
// year mod 400 tracking, month walk and result registers; uses dtas_pkg
`default_nettype none

module dtas_datapath (
    input  wire                     aclk,
    input  dtas_pkg::dtas_cmd_t     cmd,
    output dtas_pkg::dtas_status_t  status,
    input  wire                     s_opcode,
    input  wire  [4:0]              s_day,
    input  wire  [3:0]              s_month,
    input  wire  [13:0]             s_year,
    input  wire  [4:0]              s_hour,
    input  wire  [5:0]              s_minute,
    input  wire  [5:0]              s_sec,
    input  wire  [30:0]             s_amount,
    output logic [4:0]              m_day_out,
    output logic [3:0]              m_month_out,
    output logic [13:0]             m_year_out,
    output logic [4:0]              m_hour_out,
    output logic [5:0]              m_minute_out,
    output logic [5:0]              m_sec_out,
    output logic                    m_year_saturated
);
    import dtas_pkg::*;

    // captured input word
    logic              op_reg,   op_next;
    logic [4:0]        day_reg,  day_next;
    logic [4:0]        hin_reg,  hin_next;
    logic [5:0]        min_reg,  min_next;
    logic [5:0]        sin_reg,  sin_next;
    logic [30:0]       amt_reg,  amt_next;

    // working state
    logic [MON_W-1:0]  mon_reg,  mon_next;
    logic [YEAR_W-1:0] year_reg, year_next;
    logic [YEAR_W-1:0] ymod_reg, ymod_next;
    logic [YQ_W-1:0]   yq_reg,   yq_next;
    logic [OFF_W-1:0]  rem_reg,  rem_next;
    logic [QD_W-1:0]   qd_reg,   qd_next;
    logic [4:0]        hr_reg,   hr_next;
    logic [5:0]        mi_reg,   mi_next;
    logic [DAYC_W-1:0] q_reg,    q_next;
    logic              sat_hi_reg, sat_hi_next;
    logic              sat_lo_reg, sat_lo_next;

    // result word
    logic [4:0]        od_reg,   od_next;
    logic [3:0]        om_reg,   om_next;
    logic [13:0]       oy_reg,   oy_next;
    logic [4:0]        oh_reg,   oh_next;
    logic [5:0]        omi_reg,  omi_next;
    logic [5:0]        os_reg,   os_next;
    logic              osat_reg, osat_next;

    // combinational helpers
    logic [OFF_W-1:0]  off_base;
    logic [52:0]       dq_prod;
    logic [26:0]       hq_prod;
    logic [20:0]       mq_prod;
    logic [20:0]       yq_prod;
    logic              leap;
    logic              cent;
    logic [4:0]        mlen_cur;
    logic [4:0]        mlen_prev;
    logic              q_neg;
    logic              in_range;
    logic              walk_done;
    logic [MON_W-1:0]  mon_clamp;

    // month clamp on capture
    always_comb begin
        mon_clamp = s_month;
        if (s_month == 4'd0) begin
            mon_clamp = MON_JAN;
        end else if (s_month > MON_DEC) begin
            mon_clamp = MON_DEC;
        end
    end

    // biased offset in seconds before the amount is applied
    assign off_base = OFF_W'(day_reg) * SECS_DAY + OFF_W'(hin_reg) * SECS_HOUR
                    + OFF_W'(min_reg) * SECS_MIN + OFF_W'(sin_reg) + OFF_BIAS;

    // reciprocal products for the day, hour, minute and year quotients
    assign dq_prod = 53'(rem_reg[OFF_W-1:DAY_PRE]) * 53'(DAY_RECIP);
    // remainder below one day fits 17 bits, below one hour 12 bits
    assign hq_prod = 27'(rem_reg[16:HR_PRE]) * 27'(HR_RECIP);
    assign mq_prod = 21'(rem_reg[11:MIN_PRE]) * 21'(MIN_RECIP);
    assign yq_prod = 21'(year_reg[YEAR_W-1:YR_PRE]) * 21'(YR_RECIP);

    // leap rule from year mod 400 and the low year bits
    assign cent = (ymod_reg == YEAR_MIN) || (ymod_reg == CENTURY)
               || (ymod_reg == (CENTURY << 1)) || (ymod_reg == (CENTURY * 14'd3));
    assign leap = (ymod_reg == YEAR_MIN) || (!cent && year_reg[1:0] == 2'b00);

    // month lengths for the forward and backward walk
    assign mlen_cur  = month_len(mon_reg, leap);
    assign mlen_prev = (mon_reg == MON_JAN) ? DAYS_LONG : month_len(mon_reg - 4'd1, leap);
    assign q_neg     = q_reg[DAYC_W-1];
    assign in_range  = !q_neg && (q_reg < DAYC_W'(mlen_cur));
    assign walk_done = sat_hi_reg || sat_lo_reg || in_range;
    assign status.walk_done = walk_done;

    // next state of the datapath
    always_comb begin
        op_next     = op_reg;
        day_next    = day_reg;
        hin_next    = hin_reg;
        min_next    = min_reg;
        sin_next    = sin_reg;
        amt_next    = amt_reg;
        mon_next    = mon_reg;
        year_next   = year_reg;
        ymod_next   = ymod_reg;
        yq_next     = yq_reg;
        rem_next    = rem_reg;
        qd_next     = qd_reg;
        hr_next     = hr_reg;
        mi_next     = mi_reg;
        q_next      = q_reg;
        sat_hi_next = sat_hi_reg;
        sat_lo_next = sat_lo_reg;
        od_next     = od_reg;
        om_next     = om_reg;
        oy_next     = oy_reg;
        oh_next     = oh_reg;
        omi_next    = omi_reg;
        os_next     = os_reg;
        osat_next   = osat_reg;

        // capture the input word
        if (cmd.load) begin
            op_next     = s_opcode;
            day_next    = s_day;
            hin_next    = s_hour;
            min_next    = s_minute;
            sin_next    = s_sec;
            amt_next    = s_amount;
            mon_next    = mon_clamp;
            year_next   = s_year;
            ymod_next   = s_year;
            sat_hi_next = 1'b0;
            sat_lo_next = 1'b0;
        end

        // apply the amount
        if (cmd.offs) begin
            rem_next = (op_reg == OP_SUB) ? off_base - OFF_W'(amt_reg)
                                          : off_base + OFF_W'(amt_reg);
        end

        // whole days, then seconds left in the day
        if (cmd.div_step) begin
            if (cmd.idx == STEP_QUO) begin
                qd_next = dq_prod[DAY_SH +: QD_W];
            end else begin
                rem_next = rem_reg - OFF_W'(qd_reg) * SECS_DAY;
            end
        end

        // year mod 400
        if (cmd.ymod_step) begin
            if (cmd.idx == STEP_QUO) begin
                yq_next = yq_prod[YR_SH +: YQ_W];
            end else begin
                ymod_next = year_reg - YEAR_W'(yq_reg) * YEAR_CYCLE;
            end
        end

        // hours, then seconds left in the hour
        if (cmd.hrs_step) begin
            q_next = DAYC_W'(qd_reg) - DAY_BIAS;
            if (cmd.idx == STEP_QUO) begin
                hr_next = hq_prod[HR_SH +: 5];
            end else begin
                rem_next = rem_reg - OFF_W'(hr_reg) * SECS_HOUR;
            end
        end

        // minutes, then seconds left in the minute
        if (cmd.min_step) begin
            if (cmd.idx == STEP_QUO) begin
                mi_next = mq_prod[MIN_SH +: 6];
            end else begin
                rem_next = rem_reg - OFF_W'(mi_reg) * SECS_MIN;
            end
        end

        // one month per cycle
        if (cmd.walk && !walk_done) begin
            if (!q_neg) begin
                q_next = q_reg - DAYC_W'(mlen_cur);
                if (mon_reg == MON_DEC) begin
                    if (year_reg >= YEAR_MAX) begin
                        sat_hi_next = 1'b1;
                    end else begin
                        mon_next  = MON_JAN;
                        year_next = year_reg + 14'd1;
                        ymod_next = (ymod_reg == YMOD_LAST) ? YEAR_MIN : ymod_reg + 14'd1;
                    end
                end else begin
                    mon_next = mon_reg + 4'd1;
                end
            end else begin
                if (mon_reg == MON_JAN) begin
                    if (year_reg == YEAR_MIN) begin
                        sat_lo_next = 1'b1;
                    end else begin
                        mon_next  = MON_DEC;
                        year_next = year_reg - 14'd1;
                        ymod_next = (ymod_reg == YEAR_MIN) ? YMOD_LAST : ymod_reg - 14'd1;
                        q_next    = q_reg + DAYC_W'(DAYS_LONG);
                    end
                end else begin
                    mon_next = mon_reg - 4'd1;
                    q_next   = q_reg + DAYC_W'(mlen_prev);
                end
            end
        end

        // result word, saturated values override
        if (cmd.out_load) begin
            if (sat_hi_reg) begin
                od_next   = DAYS_LONG;
                om_next   = MON_DEC;
                oy_next   = YEAR_MAX;
                oh_next   = 5'd23;
                omi_next  = 6'd59;
                os_next   = 6'd59;
                osat_next = 1'b1;
            end else if (sat_lo_reg) begin
                od_next   = 5'd1;
                om_next   = MON_JAN;
                oy_next   = YEAR_MIN;
                oh_next   = 5'd0;
                omi_next  = 6'd0;
                os_next   = 6'd0;
                osat_next = 1'b1;
            end else begin
                od_next   = q_reg[4:0] + 5'd1;
                om_next   = mon_reg;
                oy_next   = year_reg;
                oh_next   = hr_reg;
                omi_next  = mi_reg;
                os_next   = rem_reg[5:0];
                osat_next = 1'b0;
            end
        end
    end

    // registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        day_reg    <= day_next;
        hin_reg    <= hin_next;
        min_reg    <= min_next;
        sin_reg    <= sin_next;
        amt_reg    <= amt_next;
        mon_reg    <= mon_next;
        year_reg   <= year_next;
        ymod_reg   <= ymod_next;
        yq_reg     <= yq_next;
        rem_reg    <= rem_next;
        qd_reg     <= qd_next;
        hr_reg     <= hr_next;
        mi_reg     <= mi_next;
        q_reg      <= q_next;
        sat_hi_reg <= sat_hi_next;
        sat_lo_reg <= sat_lo_next;
        od_reg     <= od_next;
        om_reg     <= om_next;
        oy_reg     <= oy_next;
        oh_reg     <= oh_next;
        omi_reg    <= omi_next;
        os_reg     <= os_next;
        osat_reg   <= osat_next;
    end

    // result ports
    assign m_day_out        = od_reg;
    assign m_month_out      = om_reg;
    assign m_year_out       = oy_reg;
    assign m_hour_out       = oh_reg;
    assign m_minute_out     = omi_reg;
    assign m_sec_out        = os_reg;
    assign m_year_saturated = osat_reg;

endmodule

`default_nettype wire

>>> hdl/dtas_ctrl.sv
// controller: sequences capture, offset, division, time split and month walk,
// and owns both handshakes; uses dtas_pkg
`default_nettype none

module dtas_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire                     m_ready,
    output dtas_pkg::dtas_cmd_t     cmd,
    input  dtas_pkg::dtas_status_t  status
);
    import dtas_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_OFFS = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_HRS  = 3'd3;
    localparam logic [2:0] ST_MIN  = 3'd4;
    localparam logic [2:0] ST_WALK = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg,   cnt_next;
    logic             mv_reg,    mv_next;
    logic             out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = mv_reg;
    assign out_free = !mv_reg || m_ready;

    // sequencing and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.idx    = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_OFFS;
                end
            end
            ST_OFFS: begin
                cmd.offs   = 1'b1;
                cnt_next   = STEP_QUO;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step  = 1'b1;
                cmd.ymod_step = 1'b1;
                if (cnt_reg == STEP_REM) begin
                    cnt_next   = STEP_QUO;
                    state_next = ST_HRS;
                end else begin
                    cnt_next = STEP_REM;
                end
            end
            ST_HRS: begin
                cmd.hrs_step = 1'b1;
                if (cnt_reg == STEP_REM) begin
                    cnt_next   = STEP_QUO;
                    state_next = ST_MIN;
                end else begin
                    cnt_next = STEP_REM;
                end
            end
            ST_MIN: begin
                cmd.min_step = 1'b1;
                if (cnt_reg == STEP_REM) begin
                    state_next = ST_WALK;
                end else begin
                    cnt_next = STEP_REM;
                end
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (status.walk_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid
    always_comb begin
        mv_next = mv_reg;
        if (cmd.out_load) begin
            mv_next = 1'b1;
        end else if (m_ready) begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/datetime_add_subtract_seconds_core.sv
// Gregorian date-time shifter: adds or subtracts seconds from a date and time.
// The controller steps through capture, offset sum, day and year division, the hour
// and minute split and a month-by-month day carry, whose length varies with the amount.
// One word is in flight at a time; a new word is taken while the previous
// result still waits in the output register. Reset clears the controller and
// output valid; the datapath registers hold no reset.
// Depends on dtas_pkg, dtas_ctrl and dtas_datapath.
`default_nettype none

module datetime_add_subtract_seconds_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_opcode,
    input  wire  [4:0]  s_day,
    input  wire  [3:0]  s_month,
    input  wire  [13:0] s_year,
    input  wire  [4:0]  s_hour,
    input  wire  [5:0]  s_minute,
    input  wire  [5:0]  s_sec,
    input  wire  [30:0] s_amount,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [4:0]  m_day_out,
    output logic [3:0]  m_month_out,
    output logic [13:0] m_year_out,
    output logic [4:0]  m_hour_out,
    output logic [5:0]  m_minute_out,
    output logic [5:0]  m_sec_out,
    output logic        m_year_saturated
);
    import dtas_pkg::*;

    dtas_cmd_t    cmd;
    dtas_status_t status;

    // sequencing and handshakes
    dtas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // arithmetic and result registers
    dtas_datapath u_datapath (
        .aclk             (aclk),
        .cmd              (cmd),
        .status           (status),
        .s_opcode         (s_opcode),
        .s_day            (s_day),
        .s_month          (s_month),
        .s_year           (s_year),
        .s_hour           (s_hour),
        .s_minute         (s_minute),
        .s_sec            (s_sec),
        .s_amount         (s_amount),
        .m_day_out        (m_day_out),
        .m_month_out      (m_month_out),
        .m_year_out       (m_year_out),
        .m_hour_out       (m_hour_out),
        .m_minute_out     (m_minute_out),
        .m_sec_out        (m_sec_out),
        .m_year_saturated (m_year_saturated)
    );

endmodule

`default_nettype wire

>>> bench/testbench.sv
// self-checking bench for datetime_add_subtract_seconds_core: drives date/time words,
// predicts the shifted date and time, and checks every result word in order
// depends on dtas_pkg and the core RTL
`default_nettype none

module testbench;

    import dtas_pkg::*;

    // one input word and one result word, at the port widths
    typedef struct {
        bit        op;
        bit [4:0]  day;
        bit [3:0]  month;
        bit [13:0] year;
        bit [4:0]  hour;
        bit [5:0]  minute;
        bit [5:0]  sec;
        bit [30:0] amount;
    } dt_word_t;

    typedef struct {
        bit [4:0]  day;
        bit [3:0]  month;
        bit [13:0] year;
        bit [4:0]  hour;
        bit [5:0]  minute;
        bit [5:0]  sec;
        bit        saturated;
    } dt_result_t;

    localparam longint SECS_PER_DAY = 86400;
    localparam int     QUIET_LIMIT  = 8000;
    localparam int     LONG_HOLD    = 400;
    localparam int     HOLD_AT      = 40;
    localparam int     DRAIN_CYCLES = 1000;

    // holds the predicted shifts of accepted words and checks results against them
    class datetime_checker;
        dt_result_t due_results[$];
        int         errors;
        int         results_seen;

        function new();
            errors       = 0;
            results_seen = 0;
        endfunction

        static function int days_in_month(int m, int y);
            if (m == MON_FEB) begin
                return ((y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0))) ? 29 : 28;
            end
            if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
                return 30;
            end
            return 31;
        endfunction

        // shifted date and time of one word, with year clamping
        function dt_result_t shift_datetime(dt_word_t w);
            longint     offs;
            longint     days;
            longint     tod;
            int         mon;
            int         yr;
            dt_result_t res;
            mon = w.month;
            if (mon == 0) mon = MON_JAN;
            if (mon > MON_DEC) mon = MON_DEC;
            yr = w.year;
            offs = (longint'(w.day) - 1) * SECS_PER_DAY + longint'(w.hour) * 3600
                 + longint'(w.minute) * 60 + longint'(w.sec);
            offs = (w.op == OP_SUB) ? offs - longint'(w.amount) : offs + longint'(w.amount);
            days = offs / SECS_PER_DAY;
            tod  = offs % SECS_PER_DAY;
            // floor division so the time of day stays non-negative
            if (tod < 0) begin
                tod  = tod + SECS_PER_DAY;
                days = days - 1;
            end
            // carry forward month by month
            while (days >= days_in_month(mon, yr)) begin
                days = days - days_in_month(mon, yr);
                mon++;
                if (mon > MON_DEC) begin
                    if (yr >= int'(YEAR_MAX)) begin
                        res = '{5'd31, 4'd12, YEAR_MAX, 5'd23, 6'd59, 6'd59, 1'b1};
                        return res;
                    end
                    mon = MON_JAN;
                    yr++;
                end
            end
            // borrow backward month by month
            while (days < 0) begin
                if (mon == MON_JAN) begin
                    if (yr == 0) begin
                        res = '{5'd1, 4'd1, 14'd0, 5'd0, 6'd0, 6'd0, 1'b1};
                        return res;
                    end
                    mon = MON_DEC;
                    yr--;
                end else begin
                    mon--;
                end
                days = days + days_in_month(mon, yr);
            end
            res.day       = 5'(days + 1);
            res.month     = 4'(mon);
            res.year      = 14'(yr);
            res.hour      = 5'(tod / 3600);
            res.minute    = 6'((tod % 3600) / 60);
            res.sec       = 6'(tod % 60);
            res.saturated = 1'b0;
            return res;
        endfunction

        function void note_word(dt_word_t w);
            due_results.push_back(shift_datetime(w));
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(dt_result_t got);
            dt_result_t want;
            results_seen++;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %0d/%0d/%0d %0d:%0d:%0d sat %0d",
                         $time, got.day, got.month, got.year, got.hour, got.minute, got.sec,
                         got.saturated);
                return;
            end
            want = due_results.pop_front();
            compare_field("day_out", want.day, got.day);
            compare_field("month_out", want.month, got.month);
            compare_field("year_out", want.year, got.year);
            compare_field("hour_out", want.hour, got.hour);
            compare_field("minute_out", want.minute, got.minute);
            compare_field("sec_out", want.sec, got.sec);
            compare_field("year_saturated", want.saturated, got.saturated);
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_opcode;
    logic [4:0]  s_day;
    logic [3:0]  s_month;
    logic [13:0] s_year;
    logic [4:0]  s_hour;
    logic [5:0]  s_minute;
    logic [5:0]  s_sec;
    logic [30:0] s_amount;
    logic        m_valid;
    logic        m_ready;
    logic [4:0]  m_day_out;
    logic [3:0]  m_month_out;
    logic [13:0] m_year_out;
    logic [4:0]  m_hour_out;
    logic [5:0]  m_minute_out;
    logic [5:0]  m_sec_out;
    logic        m_year_saturated;

    datetime_checker sb;
    bit              idle_on;
    bit              hold_done;
    int              quiet_cycles = 0;

    datetime_add_subtract_seconds_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_day           (s_day),
        .s_month         (s_month),
        .s_year          (s_year),
        .s_hour          (s_hour),
        .s_minute        (s_minute),
        .s_sec           (s_sec),
        .s_amount        (s_amount),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_day_out       (m_day_out),
        .m_month_out     (m_month_out),
        .m_year_out      (m_year_out),
        .m_hour_out      (m_hour_out),
        .m_minute_out    (m_minute_out),
        .m_sec_out       (m_sec_out),
        .m_year_saturated(m_year_saturated)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic dt_word_t make_word(bit op, int d, int mo, int y, int h, int mi,
                                           int s, longint amt);
        dt_word_t w;
        w.op     = op;
        w.day    = d[4:0];
        w.month  = mo[3:0];
        w.year   = y[13:0];
        w.hour   = h[4:0];
        w.minute = mi[5:0];
        w.sec    = s[5:0];
        w.amount = amt[30:0];
        return w;
    endfunction

    // mostly valid dates with random content, some raw noise over the full widths
    function automatic dt_word_t random_word();
        dt_word_t w;
        int       mon;
        int       yr;
        w.op = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 15) begin
            w.day    = 5'($urandom_range(0, 31));
            w.month  = 4'($urandom_range(0, 15));
            w.year   = 14'($urandom_range(0, 16383));
            w.hour   = 5'($urandom_range(0, 31));
            w.minute = 6'($urandom_range(0, 63));
            w.sec    = 6'($urandom_range(0, 63));
            w.amount = 31'($urandom_range(0, 32'h7FFF_FFFF));
            return w;
        end
        case ($urandom_range(0, 9))
            0:       yr = $urandom_range(0, 2);
            1:       yr = $urandom_range(16380, 16383);
            default: yr = $urandom_range(0, 9999);
        endcase
        mon      = $urandom_range(1, 12);
        w.year   = 14'(yr);
        w.month  = 4'(mon);
        w.day    = 5'($urandom_range(1, datetime_checker::days_in_month(mon, yr)));
        w.hour   = 5'($urandom_range(0, 23));
        w.minute = 6'($urandom_range(0, 59));
        w.sec    = 6'($urandom_range(0, 59));
        // most amounts short so the month walk stays brief
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w.amount = 31'($urandom_range(0, 1000000));
            4, 5, 6:    w.amount = 31'($urandom_range(0, 100000000));
            7: begin
                // whole days from midnight, the exact-borrow case
                w.amount = 31'(86400 * $urandom_range(0, 24855));
                w.hour   = '0;
                w.minute = '0;
                w.sec    = '0;
            end
            default:    w.amount = 31'($urandom_range(0, 32'h7FFF_FFFF));
        endcase
        return w;
    endfunction

    // offer one word after a random gap; returns at the falling edge after acceptance
    task automatic send_word(input dt_word_t w);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_opcode = w.op;
        s_day    = w.day;
        s_month  = w.month;
        s_year   = w.year;
        s_hour   = w.hour;
        s_minute = w.minute;
        s_sec    = w.sec;
        s_amount = w.amount;
        s_valid  = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
        @(negedge aclk);
    endtask

    // take one result word after a random stall, or the one long hold-off
    task automatic take_result();
        int         stall;
        dt_result_t got;
        @(negedge aclk);
        if (!hold_done && sb.results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            stall = LONG_HOLD;
        end else begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
        end
        if (stall > 0) begin
            m_ready = 1'b0;
            repeat (stall) @(negedge aclk);
        end
        m_ready = 1'b1;
        do @(posedge aclk); while (!m_valid);
        got.day       = m_day_out;
        got.month     = m_month_out;
        got.year      = m_year_out;
        got.hour      = m_hour_out;
        got.minute    = m_minute_out;
        got.sec       = m_sec_out;
        got.saturated = m_year_saturated;
        sb.check_result(got);
    endtask

    // result side
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever take_result();
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus
    initial begin
        sb           = new();
        idle_on      = 1'b1;
        hold_done    = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_opcode     = OP_ADD;
        s_day        = '0;
        s_month      = '0;
        s_year       = '0;
        s_hour       = '0;
        s_minute     = '0;
        s_sec        = '0;
        s_amount     = '0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // directed: rollovers, leap rules, exact day borrows, saturation, odd fields
        send_word(make_word(OP_ADD, 1, 1, 2000, 0, 0, 0, 0));
        send_word(make_word(OP_ADD, 31, 12, 1999, 23, 59, 59, 1));
        send_word(make_word(OP_ADD, 28, 2, 2000, 12, 0, 0, 86400));
        send_word(make_word(OP_ADD, 28, 2, 1900, 12, 0, 0, 86400));
        send_word(make_word(OP_ADD, 28, 2, 2024, 0, 0, 0, 86400));
        send_word(make_word(OP_SUB, 1, 3, 2023, 0, 0, 0, 86400));
        send_word(make_word(OP_SUB, 2, 1, 2000, 0, 0, 0, 172800));
        send_word(make_word(OP_SUB, 1, 1, 2000, 6, 30, 0, 21600));
        send_word(make_word(OP_SUB, 31, 12, 9999, 0, 0, 0, 2147472000));
        send_word(make_word(OP_ADD, 1, 1, 9999, 23, 59, 59, 2147483647));
        send_word(make_word(OP_SUB, 1, 1, 0, 0, 0, 0, 2147483647));
        send_word(make_word(OP_ADD, 31, 12, 16383, 0, 0, 0, 2147483647));
        send_word(make_word(OP_SUB, 1, 1, 0, 0, 0, 0, 1));
        send_word(make_word(OP_ADD, 31, 12, 16383, 23, 59, 59, 1));
        send_word(make_word(OP_ADD, 15, 0, 2021, 10, 0, 0, 3600));
        send_word(make_word(OP_SUB, 15, 13, 2021, 10, 0, 0, 3600));
        send_word(make_word(OP_ADD, 31, 15, 2021, 23, 59, 59, 1));
        send_word(make_word(OP_ADD, 0, 3, 2023, 0, 0, 0, 0));
        send_word(make_word(OP_ADD, 31, 2, 2023, 0, 0, 0, 0));
        send_word(make_word(OP_ADD, 31, 4, 2023, 12, 0, 0, 0));
        send_word(make_word(OP_ADD, 31, 15, 16383, 31, 63, 63, 2147483647));
        send_word(make_word(OP_SUB, 31, 15, 16383, 31, 63, 63, 2147483647));
        send_word(make_word(OP_SUB, 0, 0, 0, 0, 0, 0, 0));

        // sender pause until the block has drained
        s_valid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);

        // random words; the long receiver hold-off lands in here
        repeat (320) send_word(random_word());

        // back-to-back stretch with no idling on either side
        idle_on = 1'b0;
        repeat (100) send_word(random_word());
        idle_on = 1'b1;
        repeat (220) send_word(random_word());
        s_valid = 1'b0;

        // drain, then watch for stray results
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
